/* design/periodic_stencil_index_window_macros.svh */
// Assertion macros shared by the design files.
// Clocked on i_clk, disabled while i_rst_n is low.
`ifndef PERIODIC_STENCIL_INDEX_WINDOW_MACROS_SVH
`define PERIODIC_STENCIL_INDEX_WINDOW_MACROS_SVH

// same-cycle implication
`define PSIW_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PSIW_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/psiw_pkg.sv */
// Types, widths, register codes and helpers for the periodic stencil index window.
// No dependencies.
package psiw_pkg;

    localparam int MAX_GRID   = 1024;
    localparam int MAX_WINDOW = 64;

    localparam int AXES   = 3;
    localparam int AXIS_W = 2;

    localparam int POS_W     = 32;
    localparam int WIN_W     = 7;
    localparam int GRID_W    = 11;
    localparam int TC_W      = 10;
    localparam int IDX_OUT_W = 10;
    localparam int SLOT_W    = 6;
    localparam int FRAC_W    = 24;

    localparam int DIFF_W  = POS_W + 1;
    localparam int PROD_W  = DIFF_W + GRID_W;
    localparam int START_W = PROD_W - FRAC_W;
    localparam int IDX_W   = START_W + 2;
    localparam int LO_W    = TC_W + GRID_W;

    localparam int FRAC_MASK = (2 ** FRAC_W) - 1;
    localparam int HALF_Q    = 2 ** (FRAC_W - 1);

    localparam int NUM_W         = START_W + FRAC_W;
    localparam int DIV_STEP_BITS = 2;
    localparam int DIV_STEPS     = NUM_W / DIV_STEP_BITS;
    localparam int DIV_CNT_W     = $clog2(DIV_STEPS);
    localparam int SUM_W         = NUM_W + 2;

    localparam logic [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] CFG_TILE_COORD_X = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_TILE_COORD_Y = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_TILE_COORD_Z = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_ORIGIN_X     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_ORIGIN_Y     = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_ORIGIN_Z     = 3'd5;

    typedef logic [AXIS_W-1:0] t_axis;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [WIN_W-1:0]        window_size;
        logic [GRID_W-1:0]       grid_x;
        logic [GRID_W-1:0]       grid_y;
        logic [GRID_W-1:0]       grid_z;
        logic [GRID_W-1:0]       tile_x;
        logic [GRID_W-1:0]       tile_y;
        logic [GRID_W-1:0]       tile_z;
    } t_in_word;

    typedef struct packed {
        logic [SLOT_W-1:0]       slot;
        logic [IDX_OUT_W-1:0]    wrapped_x;
        logic [IDX_OUT_W-1:0]    wrapped_y;
        logic [IDX_OUT_W-1:0]    wrapped_z;
        logic                    is_last;
        logic                    overlaps;
        logic signed [POS_W-1:0] corner_x;
        logic signed [POS_W-1:0] corner_y;
        logic signed [POS_W-1:0] corner_z;
        logic [IDX_OUT_W-1:0]    tile_low_x;
        logic [IDX_OUT_W-1:0]    tile_low_y;
        logic [IDX_OUT_W-1:0]    tile_low_z;
    } t_out_word;

    typedef struct packed {
        logic [AXES-1:0][TC_W-1:0]  tile_coord;
        logic [AXES-1:0][POS_W-1:0] origin;
    } t_cfg;

    typedef struct packed {
        logic               go;
        logic               neg;
        logic [START_W-1:0] mag;
        logic [GRID_W-1:0]  den;
        logic [POS_W-1:0]   origin;
    } t_div_req;

    typedef struct packed {
        logic             idle;
        logic             done;
        logic [POS_W-1:0] corner;
    } t_div_rsp;

    function automatic logic [WIN_W-1:0] clamp_window(input logic [WIN_W-1:0] w);
        logic [WIN_W-1:0] r;
        r = w;
        if (w == '0) begin
            r = WIN_W'(1);
        end else if (w > WIN_W'(MAX_WINDOW)) begin
            r = WIN_W'(MAX_WINDOW);
        end
        return r;
    endfunction

    function automatic logic [GRID_W-1:0] clamp_grid(input logic [GRID_W-1:0] g);
        logic [GRID_W-1:0] r;
        r = g;
        if (g == '0) begin
            r = GRID_W'(1);
        end else if (g > GRID_W'(MAX_GRID)) begin
            r = GRID_W'(MAX_GRID);
        end
        return r;
    endfunction

endpackage

/* design/psiw_ifs.sv */
// Valid/ready channel interfaces for input and result words.
// Depends on psiw_pkg.
interface psiw_in_if;
    import psiw_pkg::*;
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface psiw_out_if;
    import psiw_pkg::*;
    logic      valid;
    logic      ready;
    t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* design/psiw_div.sv */
// Shared iterative divider: origin + trunc(start * 2^24 / grid), saturated.
// Two quotient bits per cycle. Depends on psiw_pkg and the macros header.
`include "periodic_stencil_index_window_macros.svh"

module psiw_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  psiw_pkg::t_div_req i_req,
    output psiw_pkg::t_div_rsp o_rsp
);
    import psiw_pkg::*;

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_STEP = 2'd1;
    localparam logic [1:0] D_FIN  = 2'd2;

    logic [1:0]           r_state;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_done;
    logic [NUM_W-1:0]     r_num;
    logic [GRID_W-1:0]    r_rem;
    logic [GRID_W-1:0]    r_den;
    logic                 r_neg;
    logic [POS_W-1:0]     r_org;
    logic [POS_W-1:0]     r_corner;

    logic [NUM_W-1:0]  n_num;
    logic [GRID_W-1:0] n_rem;
    logic [GRID_W:0]   sh;
    logic [SUM_W-1:0]  sq;
    logic [SUM_W-1:0]  sum;
    logic [POS_W-1:0]  sat;

    always_comb begin
        n_num = r_num;
        n_rem = r_rem;
        sh    = '0;
        for (int k = 0; k < DIV_STEP_BITS; k++) begin
            sh    = {n_rem, n_num[NUM_W-1]};
            n_num = {n_num[NUM_W-2:0], 1'b0};
            if (sh >= {1'b0, r_den}) begin
                n_rem    = GRID_W'(sh - {1'b0, r_den});
                n_num[0] = 1'b1;
            end else begin
                n_rem = sh[GRID_W-1:0];
            end
        end
    end

    always_comb begin
        sq  = r_neg ? (SUM_W'(0) - SUM_W'(r_num)) : SUM_W'(r_num);
        sum = {{(SUM_W-POS_W){r_org[POS_W-1]}}, r_org} + sq;
        if ((&sum[SUM_W-1:POS_W-1]) || !(|sum[SUM_W-1:POS_W-1])) begin
            sat = sum[POS_W-1:0];
        end else if (sum[SUM_W-1]) begin
            sat = POS_MIN;
        end else begin
            sat = POS_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                D_IDLE: begin
                    if (i_req.go) begin
                        r_state <= D_STEP;
                        r_cnt   <= '0;
                    end
                end
                D_STEP: begin
                    r_cnt <= r_cnt + DIV_CNT_W'(1);
                    if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                        r_state <= D_FIN;
                    end
                end
                D_FIN: begin
                    r_done  <= 1'b1;
                    r_state <= D_IDLE;
                end
                default: begin
                    r_state <= D_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == D_IDLE && i_req.go) begin
            r_num <= {i_req.mag, FRAC_W'(0)};
            r_rem <= '0;
            r_den <= i_req.den;
            r_neg <= i_req.neg;
            r_org <= i_req.origin;
        end else if (r_state == D_STEP) begin
            r_num <= n_num;
            r_rem <= n_rem;
        end
        if (r_state == D_FIN) begin
            r_corner <= sat;
        end
    end

    assign o_rsp.idle   = (r_state == D_IDLE);
    assign o_rsp.done   = r_done;
    assign o_rsp.corner = r_corner;

    `PSIW_ASSERT_NXT(a_div_launch, (r_state == D_IDLE) && i_req.go, (r_state == D_STEP) && (r_cnt == '0), "divider did not start stepping")
    `PSIW_ASSERT_IMP(a_div_rem, r_state == D_STEP, r_rem < r_den, "partial remainder not below divisor")
    `PSIW_ASSERT_NXT(a_div_pulse, r_done, !r_done, "done held longer than one cycle")

endmodule

/* design/psiw_seq.sv */
// Sequencer: start index per axis, slot walk with periodic wrap and tile overlap,
// corner divisions dispatched to the shared divider. Depends on psiw_pkg, macros.
`include "periodic_stencil_index_window_macros.svh"

module psiw_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  psiw_pkg::t_cfg      i_cfg,
    input  logic                i_in_valid,
    input  psiw_pkg::t_in_word  i_in_word,
    output logic                o_in_ready,
    input  logic                i_can_load,
    output logic                o_emit_valid,
    output psiw_pkg::t_out_word o_emit_word,
    output psiw_pkg::t_div_req  o_div_req,
    input  psiw_pkg::t_div_rsp  i_div_rsp
);
    import psiw_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SUB  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_RND  = 3'd3;
    localparam logic [2:0] S_RUN  = 3'd4;

    logic [2:0]        r_state, n_state;
    t_axis             r_axis;
    logic [SLOT_W-1:0] r_slot;
    logic [AXES-1:0]   r_hit;
    t_axis             r_div_axis;
    logic              r_div_busy;

    logic [WIN_W-1:0]                r_w;
    logic [AXES-1:0][POS_W-1:0]      r_pos;
    logic [AXES-1:0][GRID_W-1:0]     r_grid;
    logic [AXES-1:0][GRID_W-1:0]     r_tsz;
    logic signed [DIFF_W-1:0]        r_diff;
    logic signed [PROD_W-1:0]        r_prod;
    logic [AXES-1:0][LO_W-1:0]       r_lo;
    logic [AXES-1:0][START_W-1:0]    r_start;
    logic [AXES-1:0][POS_W-1:0]      r_corner;

    logic                     in_acc;
    logic [POS_W-1:0]         pos_sel;
    logic [POS_W-1:0]         org_sel;
    logic signed [DIFF_W-1:0] diff_c;
    logic signed [PROD_W:0]   prod_full;
    logic [LO_W-1:0]          lo_c;
    logic [PROD_W-1:0]        p_bias;
    logic                     round_up;
    logic [START_W-1:0]       start_c;

    logic signed [IDX_W-1:0] idx_c [AXES];
    logic signed [IDX_W-1:0] grd_c [AXES];
    logic signed [IDX_W-1:0] v_c   [AXES];
    logic signed [IDX_W-1:0] lo_e  [AXES];
    logic signed [IDX_W-1:0] hi_e  [AXES];
    logic [AXES-1:0]         hit_now;

    logic               last;
    logic               div_all;
    logic               emit_fire;
    t_axis              div_sel;
    logic [START_W-1:0] div_start;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;

    // setup datapath, one axis per pass
    always_comb begin
        pos_sel   = r_pos[r_axis];
        org_sel   = i_cfg.origin[r_axis];
        diff_c    = {pos_sel[POS_W-1], pos_sel} - {org_sel[POS_W-1], org_sel};
        lo_c      = i_cfg.tile_coord[r_axis] * r_tsz[r_axis];
        prod_full = r_diff * $signed({1'b0, r_grid[r_axis]});
        // truncate toward zero: bias negative products before the shift
        p_bias    = r_prod + (r_prod[PROD_W-1] ? PROD_W'(FRAC_MASK) : PROD_W'(0));
        round_up  = !r_prod[PROD_W-1] && (r_prod[FRAC_W-1:0] > FRAC_W'(HALF_Q));
        start_c   = p_bias[PROD_W-1:FRAC_W] + START_W'(round_up) - START_W'(r_w >> 1);
    end

    // slot lanes, one per axis
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            idx_c[a] = {{(IDX_W-START_W){r_start[a][START_W-1]}}, r_start[a]}
                     + IDX_W'(r_slot);
            grd_c[a] = IDX_W'(r_grid[a]);
            if (idx_c[a] < 0) begin
                v_c[a] = idx_c[a] + grd_c[a];
            end else if (idx_c[a] >= grd_c[a]) begin
                v_c[a] = idx_c[a] - grd_c[a];
            end else begin
                v_c[a] = idx_c[a];
            end
            lo_e[a]    = IDX_W'(r_lo[a]);
            hi_e[a]    = IDX_W'(r_lo[a]) + IDX_W'(r_tsz[a]);
            hit_now[a] = (v_c[a] >= lo_e[a]) && (v_c[a] < hi_e[a]);
        end
    end

    assign last         = (r_slot == SLOT_W'(r_w - WIN_W'(1)));
    assign div_all      = (r_div_axis == AXIS_W'(AXES));
    assign o_emit_valid = (r_state == S_RUN) && (!last || div_all);
    assign emit_fire    = o_emit_valid && i_can_load;

    always_comb begin
        o_emit_word            = '0;
        o_emit_word.slot       = r_slot;
        o_emit_word.wrapped_x  = v_c[0][IDX_OUT_W-1:0];
        o_emit_word.wrapped_y  = v_c[1][IDX_OUT_W-1:0];
        o_emit_word.wrapped_z  = v_c[2][IDX_OUT_W-1:0];
        o_emit_word.is_last    = last;
        if (last) begin
            o_emit_word.overlaps   = &(r_hit | hit_now);
            o_emit_word.corner_x   = r_corner[0];
            o_emit_word.corner_y   = r_corner[1];
            o_emit_word.corner_z   = r_corner[2];
            o_emit_word.tile_low_x = r_lo[0][IDX_OUT_W-1:0];
            o_emit_word.tile_low_y = r_lo[1][IDX_OUT_W-1:0];
            o_emit_word.tile_low_z = r_lo[2][IDX_OUT_W-1:0];
        end
    end

    // divider dispatch
    always_comb begin
        div_sel          = div_all ? t_axis'(0) : r_div_axis;
        div_start        = r_start[div_sel];
        o_div_req.go     = (r_state == S_RUN) && !r_div_busy && !div_all;
        o_div_req.neg    = div_start[START_W-1];
        o_div_req.mag    = div_start[START_W-1] ? (START_W'(0) - div_start) : div_start;
        o_div_req.den    = r_grid[div_sel];
        o_div_req.origin = i_cfg.origin[div_sel];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_acc) n_state = S_SUB;
            S_SUB:   n_state = S_MUL;
            S_MUL:   n_state = S_RND;
            S_RND:   n_state = (r_axis == AXIS_W'(AXES - 1)) ? S_RUN : S_SUB;
            S_RUN:   if (emit_fire && last) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_axis     <= '0;
            r_slot     <= '0;
            r_hit      <= '0;
            r_div_axis <= '0;
            r_div_busy <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_RND) begin
                if (r_axis == AXIS_W'(AXES - 1)) begin
                    r_axis     <= '0;
                    r_slot     <= '0;
                    r_hit      <= '0;
                    r_div_axis <= '0;
                end else begin
                    r_axis <= r_axis + AXIS_W'(1);
                end
            end
            if (emit_fire) begin
                r_slot <= r_slot + SLOT_W'(1);
                r_hit  <= r_hit | hit_now;
            end
            if (o_div_req.go) begin
                r_div_busy <= 1'b1;
            end else if (i_div_rsp.done) begin
                r_div_busy <= 1'b0;
                r_div_axis <= r_div_axis + AXIS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_w        <= clamp_window(i_in_word.window_size);
            r_pos[0]   <= i_in_word.pos_x;
            r_pos[1]   <= i_in_word.pos_y;
            r_pos[2]   <= i_in_word.pos_z;
            r_grid[0]  <= clamp_grid(i_in_word.grid_x);
            r_grid[1]  <= clamp_grid(i_in_word.grid_y);
            r_grid[2]  <= clamp_grid(i_in_word.grid_z);
            r_tsz[0]   <= i_in_word.tile_x;
            r_tsz[1]   <= i_in_word.tile_y;
            r_tsz[2]   <= i_in_word.tile_z;
        end
        if (r_state == S_SUB) begin
            r_diff         <= diff_c;
            r_lo[r_axis]   <= lo_c;
        end
        if (r_state == S_MUL) begin
            r_prod <= prod_full[PROD_W-1:0];
        end
        if (r_state == S_RND) begin
            r_start[r_axis] <= start_c;
        end
        if (r_div_busy && i_div_rsp.done) begin
            r_corner[div_sel] <= i_div_rsp.corner;
        end
    end

    `PSIW_ASSERT_NXT(a_seq_accept, in_acc, r_state == S_SUB, "accepted word did not start setup")
    `PSIW_ASSERT_IMP(a_seq_slot, r_state == S_RUN, WIN_W'(r_slot) < r_w, "slot ran past window")
    `PSIW_ASSERT_IMP(a_seq_divgo, o_div_req.go, i_div_rsp.idle, "divider launched while busy")
    `PSIW_ASSERT_NXT(a_seq_end, emit_fire && last, r_state == S_IDLE, "no return to idle after last slot")

endmodule

/* design/periodic_stencil_index_window.sv */
// Channel      Dir  Handshake            Payload
// i_in         in   valid/ready          position, window size, grid and tile sizes
// o_out        out  valid/ready          slot, wrapped indices, corner, tile low, overlap
// i_cfg_*      in   write enable only    tile coordinates and origin, index 0..5
//
// An item, once accepted, goes through per-axis setup (subtract, multiply, round),
// then three 22-step corner divisions in the shared divider, while slots stream
// out at one per cycle unless the output stalls; the last slot waits for all three.
// i_in.ready is high only between items. Output stalls hold the slot walk; the
// registered output stage takes a new word as the previous one leaves.
// Synchronous active-low reset clears the config registers and all control state.
module periodic_stencil_index_window (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [psiw_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [psiw_pkg::POS_W-1:0]        i_cfg_wdata,
    psiw_in_if.sink                           i_in,
    psiw_out_if.source                        o_out
);
    import psiw_pkg::*;

    t_cfg      r_cfg;
    logic      r_ovalid;
    t_out_word r_oword;

    logic      in_ready;
    logic      can_load;
    logic      emit_valid;
    t_out_word emit_word;
    t_div_req  div_req;
    t_div_rsp  div_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_TILE_COORD_X: r_cfg.tile_coord[0] <= i_cfg_wdata[TC_W-1:0];
                CFG_TILE_COORD_Y: r_cfg.tile_coord[1] <= i_cfg_wdata[TC_W-1:0];
                CFG_TILE_COORD_Z: r_cfg.tile_coord[2] <= i_cfg_wdata[TC_W-1:0];
                CFG_ORIGIN_X:     r_cfg.origin[0]     <= i_cfg_wdata;
                CFG_ORIGIN_Y:     r_cfg.origin[1]     <= i_cfg_wdata;
                CFG_ORIGIN_Z:     r_cfg.origin[2]     <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign can_load = !r_ovalid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (can_load) begin
            r_ovalid <= emit_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (can_load && emit_valid) begin
            r_oword <= emit_word;
        end
    end

    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_oword;
    assign i_in.ready  = in_ready;

    psiw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    psiw_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_in_valid   (i_in.valid),
        .i_in_word    (i_in.data),
        .o_in_ready   (in_ready),
        .i_can_load   (can_load),
        .o_emit_valid (emit_valid),
        .o_emit_word  (emit_word),
        .o_div_req    (div_req),
        .i_div_rsp    (div_rsp)
    );

endmodule

/* bench/psiw_window_checker.sv */
// Checker for the periodic stencil index window: tracks config writes, predicts
// every slot word of each accepted input word and compares results field by field.
// Depends on psiw_pkg and the channel interfaces in psiw_ifs.
`timescale 1ns / 100ps
module psiw_window_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [psiw_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [psiw_pkg::POS_W-1:0]      i_cfg_wdata,
    psiw_in_if                              i_in,
    psiw_out_if                             i_out,
    output int                              o_fail_count,
    output int                              o_words_due
);
    import psiw_pkg::*;

    localparam longint UNIT = longint'(1) << FRAC_W;

    logic [TC_W-1:0]         tile_coord_q [AXES];
    logic signed [POS_W-1:0] origin_q [AXES];
    t_out_word               slot_words_due [$];
    int                      mismatches = 0;

    assign o_fail_count = mismatches;

    function automatic void predict_window(input t_in_word w);
        logic signed [POS_W-1:0] pos [AXES];
        logic [GRID_W-1:0]       grid_raw [AXES];
        logic [GRID_W-1:0]       tile_raw [AXES];
        longint                  grid [AXES];
        longint                  start [AXES];
        longint                  lo [AXES];
        longint                  hi [AXES];
        longint                  corner [AXES];
        bit                      hit [AXES];
        logic [IDX_OUT_W-1:0]    idx [AXES];
        longint                  prod;
        longint                  q;
        longint                  rem;
        longint                  v;
        int                      win;
        t_out_word               o;
        pos      = '{w.pos_x, w.pos_y, w.pos_z};
        grid_raw = '{w.grid_x, w.grid_y, w.grid_z};
        tile_raw = '{w.tile_x, w.tile_y, w.tile_z};
        win = int'(w.window_size);
        if (win < 1) begin
            win = 1;
        end else if (win > MAX_WINDOW) begin
            win = MAX_WINDOW;
        end
        for (int a = 0; a < AXES; a++) begin
            grid[a] = longint'(grid_raw[a]);
            if (grid[a] < 1) begin
                grid[a] = 1;
            end else if (grid[a] > MAX_GRID) begin
                grid[a] = MAX_GRID;
            end
            // truncate toward zero, round up only above one half
            prod = (longint'(pos[a]) - longint'(origin_q[a])) * grid[a];
            q    = prod / UNIT;
            rem  = prod - q * UNIT;
            if (rem > HALF_Q) begin
                q++;
            end
            start[a]  = q - win / 2;
            lo[a]     = longint'(tile_coord_q[a]) * longint'(tile_raw[a]);
            hi[a]     = lo[a] + longint'(tile_raw[a]) - 1;
            hit[a]    = 1'b0;
            corner[a] = longint'(origin_q[a]) + (start[a] * UNIT) / grid[a];
            if (corner[a] > longint'(POS_MAX)) begin
                corner[a] = longint'(POS_MAX);
            end else if (corner[a] < -longint'(POS_MIN)) begin
                corner[a] = -longint'(POS_MIN);
            end
        end
        for (int s = 0; s < win; s++) begin
            for (int a = 0; a < AXES; a++) begin
                // single periodic wrap
                v = start[a] + s;
                if (v < 0) begin
                    v = v + grid[a];
                end else if (v > grid[a] - 1) begin
                    v = v - grid[a];
                end
                if (v >= lo[a] && v <= hi[a]) begin
                    hit[a] = 1'b1;
                end
                idx[a] = IDX_OUT_W'(v);
            end
            o = '0;
            o.slot      = SLOT_W'(s);
            o.wrapped_x = idx[0];
            o.wrapped_y = idx[1];
            o.wrapped_z = idx[2];
            if (s == win - 1) begin
                o.is_last    = 1'b1;
                o.overlaps   = hit[0] && hit[1] && hit[2];
                o.corner_x   = POS_W'(corner[0]);
                o.corner_y   = POS_W'(corner[1]);
                o.corner_z   = POS_W'(corner[2]);
                o.tile_low_x = IDX_OUT_W'(lo[0]);
                o.tile_low_y = IDX_OUT_W'(lo[1]);
                o.tile_low_z = IDX_OUT_W'(lo[2]);
            end
            slot_words_due.push_back(o);
        end
    endfunction

    function automatic void check_field(input string name, input logic signed [63:0] want,
                                        input logic signed [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void check_slot_word(input t_out_word got);
        t_out_word want;
        if (slot_words_due.size() == 0) begin
            $error("result word with nothing predicted: slot %0d", got.slot);
            mismatches++;
            return;
        end
        want = slot_words_due.pop_front();
        check_field("slot", want.slot, got.slot);
        check_field("wrapped_x", want.wrapped_x, got.wrapped_x);
        check_field("wrapped_y", want.wrapped_y, got.wrapped_y);
        check_field("wrapped_z", want.wrapped_z, got.wrapped_z);
        check_field("is_last", want.is_last, got.is_last);
        check_field("overlaps", want.overlaps, got.overlaps);
        check_field("corner_x", want.corner_x, got.corner_x);
        check_field("corner_y", want.corner_y, got.corner_y);
        check_field("corner_z", want.corner_z, got.corner_z);
        check_field("tile_low_x", want.tile_low_x, got.tile_low_x);
        check_field("tile_low_y", want.tile_low_y, got.tile_low_y);
        check_field("tile_low_z", want.tile_low_z, got.tile_low_z);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < AXES; a++) begin
                tile_coord_q[a] = '0;
                origin_q[a]     = '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_TILE_COORD_X: tile_coord_q[0] = i_cfg_wdata[TC_W-1:0];
                    CFG_TILE_COORD_Y: tile_coord_q[1] = i_cfg_wdata[TC_W-1:0];
                    CFG_TILE_COORD_Z: tile_coord_q[2] = i_cfg_wdata[TC_W-1:0];
                    CFG_ORIGIN_X:     origin_q[0]     = i_cfg_wdata;
                    CFG_ORIGIN_Y:     origin_q[1]     = i_cfg_wdata;
                    CFG_ORIGIN_Z:     origin_q[2]     = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready) begin
                predict_window(i_in.data);
            end
            if (i_out.valid && i_out.ready) begin
                check_slot_word(i_out.data);
            end
        end
        o_words_due = slot_words_due.size();
    end

endmodule

/* bench/tb_top.sv */
// Top of the periodic stencil index window bench: clock, reset, config writes,
// input words and output back-pressure; the checker module does all comparison.
// Depends on psiw_pkg, psiw_ifs, the block and psiw_window_checker.
`timescale 1ns / 100ps
module tb_top;
    import psiw_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 100;
    localparam int HOLD_CYCLES    = 400;
    localparam int IDLE_PCT       = 34;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE = '1;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [POS_W-1:0]      cfg_wdata;
    int                    fail_count;
    int                    words_due;
    int                    quiet_cycles = 0;
    bit                    steady;
    bit                    hold_arm;
    bit                    hold_done;
    logic [POS_W-1:0]      origin_now [AXES];
    t_in_word              item;

    psiw_in_if  in_ch ();
    psiw_out_if out_ch ();

    periodic_stencil_index_window u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    psiw_window_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_addr   (cfg_addr),
        .i_cfg_wdata  (cfg_wdata),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_words_due  (words_due)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // output back-pressure, with one long hold-off on request
    initial begin
        out_ch.ready = 1'b0;
        hold_done    = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_arm && !hold_done) begin
                hold_done = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            out_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || cfg_we || (in_ch.valid && in_ch.ready) ||
            (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic push_item(input t_in_word w);
        @(negedge i_clk);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= w;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (words_due != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [POS_W-1:0] val);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic load_setup(input logic [TC_W-1:0] tx, input logic [TC_W-1:0] ty,
                              input logic [TC_W-1:0] tz, input logic [POS_W-1:0] ox,
                              input logic [POS_W-1:0] oy, input logic [POS_W-1:0] oz);
        write_reg(CFG_TILE_COORD_X, POS_W'(tx));
        write_reg(CFG_TILE_COORD_Y, POS_W'(ty));
        write_reg(CFG_TILE_COORD_Z, POS_W'(tz));
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_ORIGIN_Y, oy);
        write_reg(CFG_ORIGIN_Z, oz);
        write_reg(CFG_SPARE, $urandom);
        origin_now = '{ox, oy, oz};
    endtask

    function automatic t_in_word cube(input logic [POS_W-1:0] p, input int win,
                                      input int grid, input int tile);
        t_in_word w;
        w.pos_x       = p;
        w.pos_y       = p;
        w.pos_z       = p;
        w.window_size = WIN_W'(win);
        w.grid_x      = GRID_W'(grid);
        w.grid_y      = GRID_W'(grid);
        w.grid_z      = GRID_W'(grid);
        w.tile_x      = GRID_W'(tile);
        w.tile_y      = GRID_W'(tile);
        w.tile_z      = GRID_W'(tile);
        return w;
    endfunction

    function automatic logic [GRID_W-1:0] pick_grid();
        if ($urandom_range(0, 7) == 0) begin
            return GRID_W'($urandom_range(65, MAX_GRID));
        end
        return GRID_W'($urandom_range(1, 64));
    endfunction

    function automatic logic [POS_W-1:0] near_origin(input logic [POS_W-1:0] org);
        return org + POS_W'($urandom_range(0, FRAC_MASK + HALF_Q / 2)) - POS_W'(HALF_Q / 2);
    endfunction

    // mostly positions within one unit of the origin, some fully random words
    function automatic t_in_word random_item();
        t_in_word   w;
        logic [191:0] noise;
        noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        w = noise[$bits(t_in_word)-1:0];
        if ($urandom_range(0, 4) == 0) begin
            return w;
        end
        w.window_size = ($urandom_range(0, 9) == 0) ? WIN_W'($urandom_range(13, MAX_WINDOW))
                                                    : WIN_W'($urandom_range(1, 12));
        w.grid_x = pick_grid();
        w.grid_y = pick_grid();
        w.grid_z = pick_grid();
        w.tile_x = GRID_W'($urandom_range(1, w.grid_x));
        w.tile_y = GRID_W'($urandom_range(1, w.grid_y));
        w.tile_z = GRID_W'($urandom_range(1, w.grid_z));
        w.pos_x  = near_origin(origin_now[0]);
        w.pos_y  = near_origin(origin_now[1]);
        w.pos_z  = near_origin(origin_now[2]);
        return w;
    endfunction

    initial begin
        i_rst_n      = 1'b0;
        cfg_we       = 1'b0;
        cfg_addr     = '0;
        cfg_wdata    = '0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        steady       = 1'b0;
        hold_arm     = 1'b0;
        origin_now   = '{'0, '0, '0};
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // registers at reset values
        push_item(cube(32'h0000_0000, 1, 1, 1));
        push_item(cube(32'h0000_0000, 0, 0, 0));
        push_item(cube(POS_MAX, 127, 2047, 2047));
        push_item(cube(POS_MIN, 64, 1024, 1024));
        push_item(cube(32'h0080_0000, 3, 1, 1));
        push_item(cube(32'h0080_0001, 3, 1, 1));
        push_item(cube(32'hFF40_0000, 5, 1, 1));
        push_item(cube(32'h0040_0000, 8, 16, 4));
        push_item(cube(32'h00FF_FFFF, 65, 1024, 512));
        push_item(cube(32'h0080_0000, 64, 1024, 1024));
        item = cube(32'h0010_0000, 10, 32, 3);
        item.pos_y  = 32'h00E0_0000;
        item.pos_z  = 32'hFFE0_0000;
        item.grid_y = 11'd100;
        item.grid_z = 11'd7;
        item.tile_y = 11'd50;
        item.tile_z = 11'd2000;
        push_item(item);
        push_item(cube(32'h0100_0000, 2, 2, 1));
        drain_results();

        // extreme registers: corner saturates both ways
        load_setup('1, '1, '1, POS_MAX, POS_MIN, '0);
        push_item(cube(POS_MIN, 64, 1, 1));
        push_item(cube(POS_MAX, 1, 1, 1));
        push_item(cube(32'h0000_0000, 64, 2047, 2047));
        push_item(cube(32'h1234_5678, 20, 1000, 1));
        drain_results();

        load_setup(TC_W'($urandom), TC_W'($urandom), TC_W'($urandom),
                   $urandom, $urandom, $urandom);
        repeat (35) push_item(random_item());
        drain_results();

        // small tile coordinates so windows often overlap the tile
        load_setup(TC_W'($urandom_range(0, 2)), TC_W'($urandom_range(0, 2)),
                   TC_W'($urandom_range(0, 2)),
                   POS_W'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000,
                   POS_W'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000,
                   POS_W'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000);
        push_item(random_item());
        hold_arm = 1'b1;
        repeat (34) push_item(random_item());
        drain_results();

        steady = 1'b1;
        load_setup(TC_W'($urandom_range(0, 1)), TC_W'($urandom_range(0, 1)), '0,
                   $urandom, '0, POS_W'($urandom_range(0, 32'h00FF_FFFF)));
        repeat (30) push_item(random_item());
        drain_results();
        steady = 1'b0;

        if (fail_count == 0 && words_due == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
